// File: rtl/cbe_pkg.sv
// cbe_pkg: shared types and constants of the cubic bezier easing evaluator
// register map, reset values and the control bundle handed from stage to stage
// no dependencies
package cbe_pkg;

    localparam int IO_FRAC    = 14;
    localparam int X_W        = 15;
    localparam int Y_W        = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // register indexes
    localparam t_cfg_idx REG_CTRL1_X = 8'd0;
    localparam t_cfg_idx REG_CTRL1_Y = 8'd1;
    localparam t_cfg_idx REG_CTRL2_X = 8'd2;
    localparam t_cfg_idx REG_CTRL2_Y = 8'd3;

    // register reset values
    localparam logic [X_W-1:0] CTRL1_X_RST = 15'd4096;
    localparam logic [Y_W-1:0] CTRL1_Y_RST = 16'd4096;
    localparam logic [X_W-1:0] CTRL2_X_RST = 15'd12288;
    localparam logic [Y_W-1:0] CTRL2_Y_RST = 16'd12288;

    // control that travels with every item
    typedef struct packed {
        logic valid;
        logic flat;
    } t_ctl;

endpackage

// File: rtl/cbe_mul.sv
// cbe_mul: registered fixed-point multiplier, rounded half away from zero
// result saturated to the internal range; no package dependency
module cbe_mul #(
    parameter int W = 22,
    parameter int F = 14
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output logic signed [W-1:0] o_p
);
    localparam int PW = 2*W - 1;
    localparam logic [W-2:0] LIM = '1;

    logic signed [W-1:0] neg_a, neg_b;
    logic [W-2:0]        ua, ub, ms;
    logic [PW-1:0]       prod;
    logic [PW-1-F:0]     m;
    logic                neg;
    logic signed [W-1:0] n_p, r_p;

    always_comb begin
        neg   = i_a[W-1] ^ i_b[W-1];
        neg_a = -i_a;
        neg_b = -i_b;
        ua    = i_a[W-1] ? neg_a[W-2:0] : i_a[W-2:0];
        ub    = i_b[W-1] ? neg_b[W-2:0] : i_b[W-2:0];
        prod  = PW'(ua) * PW'(ub) + (PW'(1) << (F-1));
        m     = prod[PW-1:F];
        ms    = (m > (PW-F)'(LIM)) ? LIM : m[W-2:0];
        n_p   = neg ? -$signed({1'b0, ms}) : $signed({1'b0, ms});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// File: rtl/cbe_div_step.sv
// cbe_div_step: one restoring division step, one quotient bit per stage
// uses cbe_pkg for the control bundle
module cbe_div_step #(
    parameter int RW    = 29,
    parameter int DW    = 21,
    parameter int QW    = 21,
    parameter int SHIFT = 0,
    parameter int PW    = 69
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  cbe_pkg::t_ctl  i_ctl,
    input  logic [RW-1:0]  i_rem,
    input  logic [DW-1:0]  i_div,
    input  logic [QW-1:0]  i_quot,
    input  logic [PW-1:0]  i_pay,
    output cbe_pkg::t_ctl  o_ctl,
    output logic [RW-1:0]  o_rem,
    output logic [DW-1:0]  o_div,
    output logic [QW-1:0]  o_quot,
    output logic [PW-1:0]  o_pay
);
    import cbe_pkg::*;

    localparam int CW = (RW > DW + SHIFT) ? RW : DW + SHIFT;

    logic [CW-1:0] remx, dsh;
    logic          take;
    logic [RW-1:0] n_rem;
    logic [QW-1:0] n_quot;

    t_ctl          r_ctl;
    logic [RW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [QW-1:0] r_quot;
    logic [PW-1:0] r_pay;

    always_comb begin
        remx   = CW'(i_rem);
        dsh    = CW'(i_div) << SHIFT;
        take   = remx >= dsh;
        n_rem  = take ? RW'(remx - dsh) : i_rem;
        n_quot = i_quot | (QW'(take) << SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_div  <= i_div;
            r_quot <= n_quot;
            r_pay  <= i_pay;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_div  = r_div;
    assign o_quot = r_quot;
    assign o_pay  = r_pay;

endmodule

// File: rtl/cbe_newton_cell.sv
// cbe_newton_cell: one pipelined newton step t -= (X(t) - x) / X'(t)
// uses cbe_pkg, cbe_mul and cbe_div_step
module cbe_newton_cell #(
    parameter int W = 22,
    parameter int F = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  cbe_pkg::t_ctl       i_ctl,
    input  logic signed [W-1:0] i_t,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_ca,
    input  logic signed [W-1:0] i_cb,
    input  logic signed [W-1:0] i_cc,
    input  logic signed [W-1:0] i_a3,
    input  logic signed [W-1:0] i_b2,
    output cbe_pkg::t_ctl       o_ctl,
    output logic signed [W-1:0] o_t,
    output logic signed [W-1:0] o_x
);
    import cbe_pkg::*;

    localparam int RW = 2*F + 1;
    localparam int DW = W - 1;
    localparam int QW = W - 1;
    localparam int OW = DW + QW;
    localparam int PY = 3*W + 3;
    localparam logic [W-2:0]        LIM  = '1;
    localparam logic signed [W:0]   LIMX = $signed({2'b00, LIM});

    function automatic logic signed [W-1:0] sat_add(
        input logic signed [W-1:0] a,
        input logic signed [W-1:0] b,
        input logic                sub
    );
        logic signed [W:0] s;
        s = sub ? ($signed({a[W-1], a}) - $signed({b[W-1], b}))
                : ($signed({a[W-1], a}) + $signed({b[W-1], b}));
        if (s > LIMX) begin
            s = LIMX;
        end else if (s < -LIMX) begin
            s = -LIMX;
        end
        return s[W-1:0];
    endfunction

    // stage 1: lead products of both polynomials
    logic signed [W-1:0] m_e1, m_s1, r_t1, r_x1;
    t_ctl                r_ctl1;
    cbe_mul #(.W(W), .F(F)) u_me1 (.i_clk, .i_en, .i_a(i_ca), .i_b(i_t), .o_p(m_e1));
    cbe_mul #(.W(W), .F(F)) u_ms1 (.i_clk, .i_en, .i_a(i_a3), .i_b(i_t), .o_p(m_s1));

    // stage 2: add second coefficients
    logic signed [W-1:0] r_e2, r_s2, r_t2, r_x2;
    t_ctl                r_ctl2;

    // stage 3
    logic signed [W-1:0] m_e3, m_s3, r_t3, r_x3;
    t_ctl                r_ctl3;
    cbe_mul #(.W(W), .F(F)) u_me3 (.i_clk, .i_en, .i_a(r_e2), .i_b(r_t2), .o_p(m_e3));
    cbe_mul #(.W(W), .F(F)) u_ms3 (.i_clk, .i_en, .i_a(r_s2), .i_b(r_t2), .o_p(m_s3));

    // stage 4: slope complete
    logic signed [W-1:0] r_e4, r_slope4, r_t4, r_x4;
    t_ctl                r_ctl4;

    // stage 5: last product of X(t), divider setup
    logic signed [W-1:0] m_e5, r_t5, r_x5, neg_slope;
    logic [DW-1:0]       n_us, r_us5;
    logic [RW-1:0]       n_rem, r_rem5;
    logic                n_ovf, r_ovf5, r_zero5, r_neg5;
    t_ctl                r_ctl5;
    cbe_mul #(.W(W), .F(F)) u_me5 (.i_clk, .i_en, .i_a(r_e4), .i_b(r_t4), .o_p(m_e5));

    always_comb begin
        neg_slope = -r_slope4;
        n_us      = r_slope4[W-1] ? neg_slope[W-2:0] : r_slope4[W-2:0];
        n_rem     = (RW'(1) << (2*F)) + RW'(n_us >> 1);
        // quotient would not fit below the limit
        n_ovf     = OW'(n_rem) >= (OW'(n_us) << QW);
    end

    // divider chain
    t_ctl          dv_ctl  [0:QW];
    logic [RW-1:0] dv_rem  [0:QW];
    logic [DW-1:0] dv_div  [0:QW];
    logic [QW-1:0] dv_quot [0:QW];
    logic [PY-1:0] dv_pay  [0:QW];

    assign dv_ctl[0]  = r_ctl5;
    assign dv_rem[0]  = r_rem5;
    assign dv_div[0]  = r_us5;
    assign dv_quot[0] = '0;
    assign dv_pay[0]  = {m_e5, r_t5, r_x5, r_ovf5, r_zero5, r_neg5};

    for (genvar j = 0; j < QW; j++) begin : g_div
        cbe_div_step #(
            .RW(RW), .DW(DW), .QW(QW), .SHIFT(QW-1-j), .PW(PY)
        ) u_step (
            .i_clk, .i_rst_n, .i_en,
            .i_ctl(dv_ctl[j]), .i_rem(dv_rem[j]), .i_div(dv_div[j]),
            .i_quot(dv_quot[j]), .i_pay(dv_pay[j]),
            .o_ctl(dv_ctl[j+1]), .o_rem(dv_rem[j+1]), .o_div(dv_div[j+1]),
            .o_quot(dv_quot[j+1]), .o_pay(dv_pay[j+1])
        );
    end

    logic signed [W-1:0] d_e, d_t, d_x;
    logic                d_ovf, d_zero, d_neg;
    assign {d_e, d_t, d_x, d_ovf, d_zero, d_neg} = dv_pay[QW];

    // stage r: error and signed reciprocal
    logic [W-2:0]        mag;
    logic signed [W-1:0] n_rec, r_errR, r_recR, r_tR, r_xR;
    logic                r_zeroR;
    t_ctl                r_ctlR;

    always_comb begin
        mag   = d_ovf ? LIM : dv_quot[QW];
        n_rec = d_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    // stage p: step size
    logic signed [W-1:0] m_p, r_tP, r_xP;
    logic                r_zeroP;
    t_ctl                r_ctlP;
    cbe_mul #(.W(W), .F(F)) u_mp (.i_clk, .i_en, .i_a(r_errR), .i_b(r_recR), .o_p(m_p));

    // stage u: update, a zero slope leaves t as is
    logic signed [W-1:0] r_tU, r_xU;
    t_ctl                r_ctlU;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_ctl4 <= '0;
            r_ctl5 <= '0;
            r_ctlR <= '0;
            r_ctlP <= '0;
            r_ctlU <= '0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
            r_ctl4 <= r_ctl3;
            r_ctl5 <= r_ctl4;
            r_ctlR <= dv_ctl[QW];
            r_ctlP <= r_ctlR;
            r_ctlU <= '{valid: r_ctlP.valid, flat: r_ctlP.flat | r_zeroP};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1     <= i_t;
            r_x1     <= i_x;
            r_e2     <= sat_add(m_e1, i_cb, 1'b0);
            r_s2     <= sat_add(m_s1, i_b2, 1'b0);
            r_t2     <= r_t1;
            r_x2     <= r_x1;
            r_t3     <= r_t2;
            r_x3     <= r_x2;
            r_e4     <= sat_add(m_e3, i_cc, 1'b0);
            r_slope4 <= sat_add(m_s3, i_cc, 1'b0);
            r_t4     <= r_t3;
            r_x4     <= r_x3;
            r_us5    <= n_us;
            r_rem5   <= n_rem;
            r_ovf5   <= n_ovf;
            r_zero5  <= (r_slope4 == '0);
            r_neg5   <= r_slope4[W-1];
            r_t5     <= r_t4;
            r_x5     <= r_x4;
            r_errR   <= sat_add(d_e, d_x, 1'b1);
            r_recR   <= n_rec;
            r_tR     <= d_t;
            r_xR     <= d_x;
            r_zeroR  <= d_zero;
            r_tP     <= r_tR;
            r_xP     <= r_xR;
            r_zeroP  <= r_zeroR;
            r_tU     <= r_zeroP ? r_tP : sat_add(r_tP, m_p, 1'b1);
            r_xU     <= r_xP;
        end
    end

    assign o_ctl = r_ctlU;
    assign o_t   = r_tU;
    assign o_x   = r_xU;

endmodule

// File: rtl/cubic_bezier_easing_eval_core.sv
// cubic_bezier_easing_eval_core: cubic bezier easing curve, newton solve then y(t)
// throughput: one item per cycle unless a held result stalls the pipeline
// each newton cell's bit-per-stage divider sets the pipeline depth
// the whole pipeline holds while a finished result waits at the output register
// reset (synchronous, active low) clears all valid bits and loads control point defaults
// depends on cbe_pkg, cbe_newton_cell, cbe_div_step and cbe_mul
module cubic_bezier_easing_eval_core #(
    parameter int NEWTON_STEPS = 5,
    parameter int FRAC_BITS    = 14
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // item input
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [cbe_pkg::X_W-1:0]            i_progress_x,
    // result output
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [cbe_pkg::Y_W-1:0]     o_eased_y,
    output logic                               o_flat_slope,
    // register writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  cbe_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [cbe_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import cbe_pkg::*;

    // internal word: FRAC_BITS fraction bits, range just under +-128.0
    localparam int W   = FRAC_BITS + 8;
    localparam int CW  = W + 4;
    localparam int UP  = (FRAC_BITS >= IO_FRAC) ? FRAC_BITS - IO_FRAC : 0;
    localparam int DN  = (FRAC_BITS <  IO_FRAC) ? IO_FRAC - FRAC_BITS : 0;
    localparam int DNR = (DN > 0) ? DN - 1 : 0;
    localparam int SHR = (UP > 0) ? UP - 1 : 0;
    localparam logic [W-2:0]         LIM  = '1;
    localparam logic signed [W:0]    LIMX = $signed({2'b00, LIM});
    localparam logic signed [CW-1:0] LIMC = $signed(CW'(LIM));
    localparam logic signed [CW-1:0] ONE  = $signed(CW'(1) << FRAC_BITS);

    // io format to internal format, rounding when fraction bits are dropped
    function automatic logic signed [W-1:0] from_io(input logic signed [16:0] v);
        logic signed [W+16:0] wv;
        logic [16:0]          m;
        logic [16:0]          r;
        logic signed [16:0]   nv;
        nv = -v;
        if (DN == 0) begin
            wv = (W+17)'(v) <<< UP;
            return wv[W-1:0];
        end
        m = v[16] ? nv : v;
        r = (m + (17'(1) << DNR)) >> DN;
        return v[16] ? -$signed(W'(r)) : $signed(W'(r));
    endfunction

    // internal format back to Q2.14, saturated to 16 bits
    function automatic logic signed [Y_W-1:0] to_io(input logic signed [W-1:0] v);
        logic signed [W+7:0] r;
        logic signed [W-1:0] nv;
        logic [W-1:0]        m;
        nv = -v;
        if (UP > 0) begin
            m = v[W-1] ? nv : v;
            m = (m + (W'(1) << SHR)) >> UP;
            r = $signed((W+8)'(m));
            if (v[W-1]) begin
                r = -r;
            end
        end else begin
            r = (W+8)'(v) <<< DN;
        end
        if (r > (W+8)'(32767)) begin
            return 16'sh7fff;
        end else if (r < -(W+8)'(32768)) begin
            return 16'sh8000;
        end
        return r[Y_W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_c(input logic signed [CW-1:0] v);
        if (v > LIMC) begin
            return LIMC[W-1:0];
        end else if (v < -LIMC) begin
            return -LIMC[W-1:0];
        end
        return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_add(
        input logic signed [W-1:0] a,
        input logic signed [W-1:0] b
    );
        logic signed [W:0] s;
        s = $signed({a[W-1], a}) + $signed({b[W-1], b});
        if (s > LIMX) begin
            s = LIMX;
        end else if (s < -LIMX) begin
            s = -LIMX;
        end
        return s[W-1:0];
    endfunction

    // ---------------------------------------------------------------
    // control point registers, always ready
    // ---------------------------------------------------------------
    logic [X_W-1:0] r_ctrl1_x, r_ctrl2_x;
    logic [Y_W-1:0] r_ctrl1_y, r_ctrl2_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl1_x <= CTRL1_X_RST;
            r_ctrl1_y <= CTRL1_Y_RST;
            r_ctrl2_x <= CTRL2_X_RST;
            r_ctrl2_y <= CTRL2_Y_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CTRL1_X: r_ctrl1_x <= i_cfg_data[X_W-1:0];
                REG_CTRL1_Y: r_ctrl1_y <= i_cfg_data[Y_W-1:0];
                REG_CTRL2_X: r_ctrl2_x <= i_cfg_data[X_W-1:0];
                REG_CTRL2_Y: r_ctrl2_y <= i_cfg_data[Y_W-1:0];
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // polynomial coefficients, registered from the control point registers
    // X(t) = A t^3 + B t^2 + C t and Y(t) = E t^3 + F t^2 + G t
    // ---------------------------------------------------------------
    logic signed [W-1:0]  x1, x2, y1, y2;
    logic signed [CW-1:0] x1e, x2e, y1e, y2e;
    logic signed [W-1:0]  n_ca, n_cb;
    logic signed [W-1:0]  r_ca, r_cb, r_cc, r_a3, r_b2, r_ce, r_cf, r_cg;

    always_comb begin
        x1   = from_io($signed({2'b00, r_ctrl1_x}));
        x2   = from_io($signed({2'b00, r_ctrl2_x}));
        y1   = from_io($signed({r_ctrl1_y[Y_W-1], r_ctrl1_y}));
        y2   = from_io($signed({r_ctrl2_y[Y_W-1], r_ctrl2_y}));
        x1e  = CW'(x1);
        x2e  = CW'(x2);
        y1e  = CW'(y1);
        y2e  = CW'(y2);
        n_ca = sat_c(CW'(ONE - 3*x2e + 3*x1e));
        n_cb = sat_c(CW'(3*x2e - 6*x1e));
    end

    always_ff @(posedge i_clk) begin
        r_ca <= n_ca;
        r_cb <= n_cb;
        r_cc <= sat_c(CW'(3*x1e));
        r_a3 <= sat_c(CW'(3*CW'(n_ca)));
        r_b2 <= sat_c(CW'(2*CW'(n_cb)));
        r_ce <= sat_c(CW'(ONE - 3*y2e + 3*y1e));
        r_cf <= sat_c(CW'(3*y2e - 6*y1e));
        r_cg <= sat_c(CW'(3*y1e));
    end

    // ---------------------------------------------------------------
    // flow control: every stage moves unless the output item is held
    // ---------------------------------------------------------------
    logic adv;
    logic r_out_valid;
    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = adv;

    // input stage, t starts at x
    t_ctl                r_ctl0;
    logic signed [W-1:0] r_x0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else if (adv) begin
            r_ctl0 <= '{valid: i_in_valid, flat: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x0 <= from_io($signed({2'b00, i_progress_x}));
        end
    end

    // ---------------------------------------------------------------
    // row of newton cells, each one full step deep
    // ---------------------------------------------------------------
    t_ctl                cl_ctl [0:NEWTON_STEPS];
    logic signed [W-1:0] cl_t   [0:NEWTON_STEPS];
    logic signed [W-1:0] cl_x   [0:NEWTON_STEPS];

    assign cl_ctl[0] = r_ctl0;
    assign cl_t[0]   = r_x0;
    assign cl_x[0]   = r_x0;

    for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_cell
        cbe_newton_cell #(.W(W), .F(FRAC_BITS)) u_cell (
            .i_clk, .i_rst_n, .i_en(adv),
            .i_ctl(cl_ctl[k]), .i_t(cl_t[k]), .i_x(cl_x[k]),
            .i_ca(r_ca), .i_cb(r_cb), .i_cc(r_cc), .i_a3(r_a3), .i_b2(r_b2),
            .o_ctl(cl_ctl[k+1]), .o_t(cl_t[k+1]), .o_x(cl_x[k+1])
        );
    end

    // ---------------------------------------------------------------
    // y(t) in horner form: mul, add, mul, add, mul
    // ---------------------------------------------------------------
    logic signed [W-1:0] m_y1, m_y3, m_y5;
    logic signed [W-1:0] r_t_y1, r_t_y2, r_t_y3, r_t_y4, r_h_y2, r_h_y4;
    t_ctl                r_ctl_y1, r_ctl_y2, r_ctl_y3, r_ctl_y4, r_ctl_y5;

    cbe_mul #(.W(W), .F(FRAC_BITS)) u_my1 (
        .i_clk, .i_en(adv), .i_a(r_ce), .i_b(cl_t[NEWTON_STEPS]), .o_p(m_y1)
    );
    cbe_mul #(.W(W), .F(FRAC_BITS)) u_my3 (
        .i_clk, .i_en(adv), .i_a(r_h_y2), .i_b(r_t_y2), .o_p(m_y3)
    );
    cbe_mul #(.W(W), .F(FRAC_BITS)) u_my5 (
        .i_clk, .i_en(adv), .i_a(r_h_y4), .i_b(r_t_y4), .o_p(m_y5)
    );

    // output register
    logic signed [Y_W-1:0] r_eased_y;
    logic                  r_flat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_y1    <= '0;
            r_ctl_y2    <= '0;
            r_ctl_y3    <= '0;
            r_ctl_y4    <= '0;
            r_ctl_y5    <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_ctl_y1    <= cl_ctl[NEWTON_STEPS];
            r_ctl_y2    <= r_ctl_y1;
            r_ctl_y3    <= r_ctl_y2;
            r_ctl_y4    <= r_ctl_y3;
            r_ctl_y5    <= r_ctl_y4;
            r_out_valid <= r_ctl_y5.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_t_y1    <= cl_t[NEWTON_STEPS];
            r_t_y2    <= r_t_y1;
            r_h_y2    <= sat_add(m_y1, r_cf);
            r_t_y3    <= r_t_y2;
            r_t_y4    <= r_t_y3;
            r_h_y4    <= sat_add(m_y3, r_cg);
            r_eased_y <= to_io(m_y5);
            r_flat    <= r_ctl_y5.flat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_eased_y    = r_eased_y;
    assign o_flat_slope = r_flat;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input held off without a waiting result");

    a_item_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_ctl0.valid)
        else $error("accepted item missing from input stage");

    a_item_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_ctl_y5.valid) |=> o_out_valid)
        else $error("finished item did not reach output register");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(r_ctl_y5)))
        else $error("pipeline moved while a result was held");

endmodule
